>>> rtl/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types, constants and helpers of the 24-bit BMP stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM) + 1;
  localparam int unsigned PAD_W   = DIM_W + 2;
  localparam int unsigned PROD_W  = PAD_W + DIM_W;
  localparam int unsigned CNT_W   = 12;

  localparam logic [31:0] MIN_FILE_LEN = 32'd14;
  localparam logic [31:0] HDR_LEN      = 32'd34;
  localparam logic [15:0] DEPTH_24     = 16'd24;

  localparam logic [31:0] POS_SIG0    = 32'd0;
  localparam logic [31:0] POS_SIG1    = 32'd1;
  localparam logic [31:0] POS_OFF_LO  = 32'd10;
  localparam logic [31:0] POS_OFF_HI  = 32'd13;
  localparam logic [31:0] POS_WID_LO  = 32'd18;
  localparam logic [31:0] POS_WID_HI  = 32'd21;
  localparam logic [31:0] POS_HGT_LO  = 32'd22;
  localparam logic [31:0] POS_HGT_HI  = 32'd25;
  localparam logic [31:0] POS_DEP_LO  = 32'd28;
  localparam logic [31:0] POS_DEP_HI  = 32'd29;
  localparam logic [31:0] POS_CMP_LO  = 32'd30;
  localparam logic [31:0] POS_CMP_HI  = 32'd33;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_SKIP   = 3'd2,
    PH_PIXEL  = 3'd3,
    PH_PAD    = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_FORMAT = 2'd1,
    ERR_UNSUP  = 2'd2
  } err_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_ERROR = 1'b1
  } kind_e;

  typedef struct packed {
    logic [31:0] pix_offset;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] depth;
    logic [31:0] compression;
    logic        sig_ok;
  } hdr_t;

  typedef struct packed {
    logic off_bad;
    err_e img_code;
  } chk_t;

  typedef struct packed {
    kind_e            kind;
    err_e             code;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last;
  } res_t;

  function automatic logic height_up(input logic [31:0] h);
    return (h != 32'd0) && !h[31];
  endfunction

  function automatic logic [31:0] height_mag(input logic [31:0] h);
    return height_up(h) ? h : (32'd0 - h);
  endfunction

endpackage

>>> rtl/bmp24_stream_decoder.sv
// ----------------------------------------------------------------------------
// bmp24_stream_decoder
// Streaming decoder for uncompressed 24-bit BMP files, one byte per beat.
// ----------------------------------------------------------------------------
// channel   direction  payload
// s_axis    in         tdata: data_byte; tuser: start_of_file
// m_axis    out        tdata: error_code, pixel_row, dest_column, red, green,
//                      blue; tuser: result_kind; tlast: final_item
// cfg       in         cfg_wdata_i: file_length, written when cfg_we_i is high
//
// one byte per cycle sustained while m_axis is ready; each beat passes an
// input register and then a result register on its way to m_axis
// the pixel-row size product is registered ahead of the byte 33 check
// reset clears the parser state, both valid flags and file_length
// a stalled result holds the result register; the input register still
// takes a beat while it is empty
// ----------------------------------------------------------------------------
module bmp24_stream_decoder import bmpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] start_of_file
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [1:0] error_code, [13:2] pixel_row,
                                        // [25:14] dest_column, [33:26] red,
                                        // [41:34] green, [49:42] blue, rest 0
  output logic        m_axis_tuser_o,   // [0] result_kind
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0] file_len_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_sof_q;
  logic        out_valid_q;
  res_t        out_q;
  logic        advance;
  logic        fire;
  logic        res_valid;
  res_t        res;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len_q <= '0;
    end else if (cfg_we_i) begin
      file_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_sof_q  <= s_axis_tuser_i;
    end
  end

  bmpd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .sof_i       (in_sof_q),
    .file_len_i  (file_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_q.blue, out_q.green, out_q.red,
                            out_q.col, out_q.row, out_q.code};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;

endmodule

>>> rtl/bmpd_hdr_check.sv
// ----------------------------------------------------------------------------
// bmpd_hdr_check
// Header checks: offset checks at byte 13, image checks at byte 33.
// ----------------------------------------------------------------------------
module bmpd_hdr_check import bmpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hdr_t        hdr_i,
  input  logic [7:0]  byte_i,
  input  logic [31:0] file_len_i,
  output chk_t        chk_o
);

  logic [31:0]       off_full;
  logic [31:0]       cmp_full;
  logic [31:0]       hmag;
  logic [DIM_W-1:0]  w_n;
  logic [DIM_W-1:0]  h_n;
  logic [PAD_W-1:0]  w3;
  logic [PAD_W-1:0]  padded;
  logic [PROD_W-1:0] prod_d, prod_q;
  logic [32:0]       need;
  logic              off_bad;
  err_e              img_code;

  // the top byte of offset and compression arrives with the checking beat
  assign off_full = {byte_i, hdr_i.pix_offset[23:0]};
  assign cmp_full = {byte_i, hdr_i.compression[23:0]};
  assign hmag     = height_mag(hdr_i.height);

  // padded row size times height, settled well before byte 33
  assign w_n    = hdr_i.width[DIM_W-1:0];
  assign h_n    = hmag[DIM_W-1:0];
  assign w3     = {1'b0, w_n, 1'b0} + {2'b00, w_n} + PAD_W'(3);
  assign padded = w3 & ~PAD_W'(3);
  assign prod_d = PROD_W'(padded) * PROD_W'(h_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else begin
      prod_q <= prod_d;
    end
  end

  assign need = {1'b0, hdr_i.pix_offset} + 33'(prod_q);

  assign off_bad = !hdr_i.sig_ok || (off_full >= file_len_i) || (off_full < HDR_LEN);

  always_comb begin
    priority if (cmp_full != 32'd0) begin
      img_code = ERR_UNSUP;
    end else if (hdr_i.depth != DEPTH_24) begin
      img_code = ERR_UNSUP;
    end else if (hdr_i.width == 32'd0 || hdr_i.width[31] || hdr_i.height == 32'd0) begin
      img_code = ERR_FORMAT;
    end else if (hdr_i.width > 32'(MAX_DIM) || hmag > 32'(MAX_DIM)) begin
      img_code = ERR_UNSUP;
    end else if (need > {1'b0, file_len_i}) begin
      img_code = ERR_FORMAT;
    end else begin
      img_code = ERR_NONE;
    end
  end

  assign chk_o = {off_bad, img_code};

endmodule

>>> rtl/bmpd_parser.sv
// ----------------------------------------------------------------------------
// bmpd_parser
// Parse state machine: header capture, skip, pixel assembly and padding.
// ----------------------------------------------------------------------------
module bmpd_parser import bmpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  byte_i,
  input  logic        sof_i,
  input  logic [31:0] file_len_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  phase_e           phase_d, phase_q;
  logic [31:0]      pos_d, pos_q;
  hdr_t             hdr_d, hdr_q;
  logic [CNT_W-1:0] row_d, row_q;
  logic [CNT_W-1:0] col_d, col_q;
  logic [1:0]       bip_d, bip_q;
  logic [1:0]       pad_d, pad_q;
  logic [7:0]       blue_d, blue_q;
  logic [7:0]       green_d, green_q;
  chk_t             chk;
  logic [31:0]      hmag32;
  logic [DIM_W-1:0] hmag;
  logic [DIM_W-1:0] drow;

  bmpd_hdr_check u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hdr_i      (hdr_q),
    .byte_i     (byte_i),
    .file_len_i (file_len_i),
    .chk_o      (chk)
  );

  assign hmag32 = height_mag(hdr_q.height);
  assign hmag   = hmag32[DIM_W-1:0];
  assign drow   = hmag - DIM_W'(1) - DIM_W'(row_q);

  always_comb begin
    logic       go;
    logic       pix;
    logic       last_col;
    logic       last;
    logic [1:0] lane;
    go          = 1'b0;
    pix         = 1'b0;
    last_col    = 1'b0;
    last        = 1'b0;
    lane        = 2'd0;
    phase_d     = phase_q;
    pos_d       = pos_q;
    hdr_d       = hdr_q;
    row_d       = row_q;
    col_d       = col_q;
    bip_d       = bip_q;
    pad_d       = pad_q;
    blue_d      = blue_q;
    green_d     = green_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (sof_i) begin
      phase_d = PH_HEADER;
      pos_d   = '0;
      hdr_d   = '0;
      row_d   = '0;
      col_d   = '0;
      bip_d   = '0;
      pad_d   = '0;
      blue_d  = '0;
      green_d = '0;
      if (file_len_i < MIN_FILE_LEN) begin
        phase_d      = PH_DONE;
        res_valid_o  = 1'b1;
        res_o.kind   = KIND_ERROR;
        res_o.code   = ERR_FORMAT;
        res_o.last   = 1'b1;
      end else begin
        go = 1'b1;
      end
    end else if (phase_q == PH_HEADER || phase_q == PH_SKIP ||
                 phase_q == PH_PIXEL || phase_q == PH_PAD) begin
      pos_d = pos_q + 32'd1;
      go    = 1'b1;
    end

    if (go) begin
      unique case (phase_d)
        PH_HEADER: begin
          // byte lane within a 32-bit field that starts at a position of 2 mod 4
          lane = pos_d[1:0] - 2'd2;
          if (pos_d == POS_SIG0) begin
            hdr_d.sig_ok = (byte_i == SIG_B);
          end else if (pos_d == POS_SIG1) begin
            hdr_d.sig_ok = hdr_q.sig_ok && (byte_i == SIG_M);
          end else if (pos_d >= POS_OFF_LO && pos_d <= POS_OFF_HI) begin
            hdr_d.pix_offset[8*lane +: 8] = byte_i;
          end else if (pos_d >= POS_WID_LO && pos_d <= POS_WID_HI) begin
            hdr_d.width[8*lane +: 8] = byte_i;
          end else if (pos_d >= POS_HGT_LO && pos_d <= POS_HGT_HI) begin
            hdr_d.height[8*lane +: 8] = byte_i;
          end else if (pos_d >= POS_DEP_LO && pos_d <= POS_DEP_HI) begin
            hdr_d.depth[8*pos_d[0] +: 8] = byte_i;
          end else if (pos_d >= POS_CMP_LO && pos_d <= POS_CMP_HI) begin
            hdr_d.compression[8*lane +: 8] = byte_i;
          end
          if (pos_d == POS_OFF_HI && chk.off_bad) begin
            phase_d     = PH_DONE;
            res_valid_o = 1'b1;
            res_o.kind  = KIND_ERROR;
            res_o.code  = ERR_FORMAT;
            res_o.last  = 1'b1;
          end else if (pos_d == POS_CMP_HI) begin
            if (chk.img_code != ERR_NONE) begin
              phase_d     = PH_DONE;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_ERROR;
              res_o.code  = chk.img_code;
              res_o.last  = 1'b1;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (pos_d == hdr_q.pix_offset) begin
            phase_d = PH_PIXEL;
            pix     = 1'b1;
          end
        end
        PH_PAD: begin
          if (pad_q > 2'd1) begin
            pad_d = pad_q - 2'd1;
          end else begin
            pad_d   = '0;
            phase_d = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          pix = 1'b1;
        end
        default: begin
          pix = 1'b0;
        end
      endcase
    end

    if (pix) begin
      unique case (bip_q)
        2'd0: begin
          blue_d = byte_i;
          bip_d  = 2'd1;
        end
        2'd1: begin
          green_d = byte_i;
          bip_d   = 2'd2;
        end
        default: begin
          bip_d       = 2'd0;
          last_col    = ({1'b0, col_q} + 13'd1) >= hdr_q.width[12:0];
          last        = last_col && (({1'b0, row_q} + 13'd1) >= 13'(hmag));
          res_valid_o = 1'b1;
          res_o.kind  = KIND_PIXEL;
          res_o.code  = ERR_NONE;
          res_o.row   = height_up(hdr_q.height) ? drow[CNT_W-1:0] : row_q;
          res_o.col   = col_q;
          res_o.red   = byte_i;
          res_o.green = green_q;
          res_o.blue  = blue_q;
          res_o.last  = last;
          if (last) begin
            phase_d = PH_DONE;
          end else if (last_col) begin
            col_d = '0;
            row_d = row_q + CNT_W'(1);
            pad_d = hdr_q.width[1:0];
            if (hdr_q.width[1:0] != 2'd0) begin
              phase_d = PH_PAD;
            end
          end else begin
            col_d = col_q + CNT_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      hdr_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      bip_q   <= '0;
      pad_q   <= '0;
      blue_q  <= '0;
      green_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
      row_q   <= row_d;
      col_q   <= col_d;
      bip_q   <= bip_d;
      pad_q   <= pad_d;
      blue_q  <= blue_d;
      green_q <= green_d;
    end
  end

endmodule

>>> tb/bmp_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_result_checker
// Watches the byte and result streams of the 24-bit BMP decoder, keeps its own
// copy of the header parser and pixel assembler, and compares every result
// beat field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module bmp_result_checker import bmpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,
  input  logic        s_user_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [55:0] m_data_i,
  input  logic        m_user_i,
  input  logic        m_last_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output int unsigned n_errors_o,
  output int unsigned n_pending_o
);

  logic [31:0] flen_q;
  logic [31:0] pos_q;
  logic [31:0] off_q;
  logic [31:0] wid_q;
  logic [31:0] hgt_q;
  logic [31:0] dep_q;
  logic [31:0] cmp_q;
  phase_e      phase_q;
  logic        sig_q;
  logic [11:0] row_q;
  logic [11:0] col_q;
  logic [1:0]  bip_q;
  logic [1:0]  pad_q;
  logic [7:0]  blu_q;
  logic [7:0]  grn_q;
  res_t        due_results[$];

  initial n_errors_o = 0;

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("checker: %s mismatch, got %0h want %0h at %0t", what, got, want, $time);
    n_errors_o++;
  endtask

  function automatic logic [31:0] le_byte(input logic [31:0] f, input logic [31:0] k,
                                          input logic [7:0] b);
    return f | ({24'd0, b} << (8 * k[1:0]));
  endfunction

  function automatic logic rows_flipped();
    return (hgt_q != 32'd0) && !hgt_q[31];
  endfunction

  function automatic logic [31:0] row_count();
    return rows_flipped() ? hgt_q : (32'd0 - hgt_q);
  endfunction

  function automatic err_e header_verdict();
    logic [31:0] mag;
    logic [63:0] padded;
    logic [63:0] need;
    if (cmp_q != 32'd0) return ERR_UNSUP;
    if (dep_q != {16'd0, DEPTH_24}) return ERR_UNSUP;
    if (wid_q == 32'd0 || wid_q[31] || hgt_q == 32'd0) return ERR_FORMAT;
    mag = row_count();
    if (wid_q > MAX_DIM || mag > MAX_DIM) return ERR_UNSUP;
    padded = ({32'd0, wid_q} * 64'd3 + 64'd3) & ~64'd3;
    need = {32'd0, off_q} + padded * {32'd0, mag};
    if (need > {32'd0, flen_q}) return ERR_FORMAT;
    return ERR_NONE;
  endfunction

  task automatic clear_parser();
    pos_q   = '0;
    phase_q = PH_IDLE;
    off_q   = '0;
    wid_q   = '0;
    hgt_q   = '0;
    dep_q   = '0;
    cmp_q   = '0;
    sig_q   = 1'b0;
    row_q   = '0;
    col_q   = '0;
    bip_q   = '0;
    pad_q   = '0;
    blu_q   = '0;
    grn_q   = '0;
  endtask

  task automatic raise_error(input err_e code);
    res_t r;
    r      = '0;
    r.kind = KIND_ERROR;
    r.code = code;
    r.last = 1'b1;
    due_results.push_back(r);
    phase_q = PH_DONE;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic sof);
    err_e        code;
    res_t        px;
    logic [31:0] mag;
    logic [31:0] drow;
    logic        last_col;
    logic        last_px;
    if (sof) begin
      clear_parser();
      phase_q = PH_HEADER;
      if (flen_q < MIN_FILE_LEN) begin
        raise_error(ERR_FORMAT);
        return;
      end
    end else if (phase_q == PH_IDLE || phase_q == PH_DONE) begin
      return;
    end else begin
      pos_q = pos_q + 32'd1;
    end

    if (phase_q == PH_HEADER) begin
      if (pos_q == POS_SIG0) sig_q = (b == SIG_B);
      else if (pos_q == POS_SIG1) sig_q = sig_q && (b == SIG_M);
      else if (pos_q >= POS_OFF_LO && pos_q <= POS_OFF_HI)
        off_q = le_byte(off_q, pos_q - POS_OFF_LO, b);
      else if (pos_q >= POS_WID_LO && pos_q <= POS_WID_HI)
        wid_q = le_byte(wid_q, pos_q - POS_WID_LO, b);
      else if (pos_q >= POS_HGT_LO && pos_q <= POS_HGT_HI)
        hgt_q = le_byte(hgt_q, pos_q - POS_HGT_LO, b);
      else if (pos_q >= POS_DEP_LO && pos_q <= POS_DEP_HI)
        dep_q = le_byte(dep_q, pos_q - POS_DEP_LO, b);
      else if (pos_q >= POS_CMP_LO && pos_q <= POS_CMP_HI)
        cmp_q = le_byte(cmp_q, pos_q - POS_CMP_LO, b);

      if (pos_q == POS_OFF_HI) begin
        if (!sig_q || off_q >= flen_q || off_q < HDR_LEN) begin
          raise_error(ERR_FORMAT);
          return;
        end
      end
      if (pos_q == POS_CMP_HI) begin
        code = header_verdict();
        if (code != ERR_NONE) begin
          raise_error(code);
          return;
        end
        phase_q = PH_SKIP;
      end
      return;
    end

    if (phase_q == PH_SKIP) begin
      if (pos_q != off_q) return;
      phase_q = PH_PIXEL;
    end

    if (phase_q == PH_PAD) begin
      if (pad_q > 2'd1) begin
        pad_q = pad_q - 2'd1;
      end else begin
        pad_q   = '0;
        phase_q = PH_PIXEL;
      end
      return;
    end

    if (bip_q == 2'd0) begin
      blu_q = b;
      bip_q = 2'd1;
      return;
    end
    if (bip_q == 2'd1) begin
      grn_q = b;
      bip_q = 2'd2;
      return;
    end
    bip_q    = 2'd0;
    mag      = row_count();
    drow     = rows_flipped() ? (mag - 32'd1 - {20'd0, row_q}) : {20'd0, row_q};
    last_col = ({20'd0, col_q} + 32'd1) >= wid_q;
    last_px  = last_col && (({20'd0, row_q} + 32'd1) >= mag);
    px.kind  = KIND_PIXEL;
    px.code  = ERR_NONE;
    px.row   = drow[11:0];
    px.col   = col_q;
    px.red   = b;
    px.green = grn_q;
    px.blue  = blu_q;
    px.last  = last_px;
    due_results.push_back(px);
    if (last_px) begin
      phase_q = PH_DONE;
    end else if (last_col) begin
      col_q = '0;
      row_q = row_q + 12'd1;
      pad_q = wid_q[1:0];
      if (pad_q != 2'd0) phase_q = PH_PAD;
    end else begin
      col_q = col_q + 12'd1;
    end
  endtask

  task automatic check_beat();
    res_t want;
    if (due_results.size() == 0) begin
      flag("unexpected result beat", m_data_i[31:0], 32'd0);
      return;
    end
    want = due_results.pop_front();
    if (m_user_i !== want.kind)
      flag("result_kind", 32'(m_user_i), 32'(want.kind));
    if (m_data_i[1:0] !== want.code)
      flag("error_code", 32'(m_data_i[1:0]), 32'(want.code));
    if (m_data_i[13:2] !== want.row)
      flag("pixel_row", 32'(m_data_i[13:2]), 32'(want.row));
    if (m_data_i[25:14] !== want.col)
      flag("dest_column", 32'(m_data_i[25:14]), 32'(want.col));
    if (m_data_i[33:26] !== want.red)
      flag("red", 32'(m_data_i[33:26]), 32'(want.red));
    if (m_data_i[41:34] !== want.green)
      flag("green", 32'(m_data_i[41:34]), 32'(want.green));
    if (m_data_i[49:42] !== want.blue)
      flag("blue", 32'(m_data_i[49:42]), 32'(want.blue));
    if (m_last_i !== want.last)
      flag("final_item", 32'(m_last_i), 32'(want.last));
    if (m_data_i[55:50] !== 6'd0)
      flag("spare tdata bits", 32'(m_data_i[55:50]), 32'd0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      flen_q = '0;
      due_results.delete();
      n_pending_o = 0;
    end else begin
      if (cfg_we_i) flen_q = cfg_wdata_i;
      if (s_valid_i && s_ready_i) decode_byte(s_data_i, s_user_i);
      if (m_valid_i && m_ready_i) check_beat();
      n_pending_o = due_results.size();
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the 24-bit BMP stream decoder: directed header corner cases,
// extreme file lengths and image sizes, then random well-formed and broken
// files under varying sender and receiver stalls. Checking is done by
// bmp_result_checker.
// ----------------------------------------------------------------------------
module tb;
  import bmpd_pkg::*;

  localparam logic [15:0] SIG_BM = {SIG_M, SIG_B};

  logic        clk;
  logic        rst_n;
  logic        s_valid;
  logic        s_ready;
  logic [7:0]  s_data;
  logic        s_user;
  logic        m_valid;
  logic        m_ready;
  logic [55:0] m_data;
  logic        m_user;
  logic        m_last;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int unsigned n_errors;
  int unsigned n_pending;

  int          snd_idle = 18;
  int          rcv_idle = 81;
  logic        hold_req = 1'b0;
  int          n_items  = 0;
  logic [7:0]  file_bytes[$];

  bmp24_stream_decoder u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  bmp_result_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_valid_i   (s_valid),
    .s_ready_i   (s_ready),
    .s_data_i    (s_data),
    .s_user_i    (s_user),
    .m_valid_i   (m_valid),
    .m_ready_i   (m_ready),
    .m_data_i    (m_data),
    .m_user_i    (m_user),
    .m_last_i    (m_last),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .n_errors_o  (n_errors),
    .n_pending_o (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("tb: errors");
    $finish;
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin
    m_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      m_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic sof);
    while ($urandom_range(99) < snd_idle) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= sof;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    s_valid <= 1'b0;
    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  function automatic logic [31:0] good_len(input logic [31:0] off, input int cols,
                                           input int rows);
    return off + ((cols * 3 + 3) & ~3) * rows;
  endfunction

  task automatic stream_file(input logic [15:0] sig, input logic [31:0] off,
                             input logic [31:0] wid, input logic [31:0] hgt,
                             input logic [15:0] dep, input logic [31:0] cmp,
                             input logic [31:0] flen, input int rows, input int cols,
                             input int cut);
    int gap;
    file_bytes.delete();
    put_le(32'(sig), 2);
    put_le($urandom, 4);
    put_le($urandom, 4);
    put_le(off, 4);
    put_le($urandom, 4);
    put_le(wid, 4);
    put_le(hgt, 4);
    put_le($urandom, 2);
    put_le(32'(dep), 2);
    put_le(cmp, 4);
    gap = (off >= 42) ? 8 : ((off > 34) ? int'(off) - 34 : 0);
    put_rand(gap + rows * (cols * 3 + (cols & 3)));

    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= flen;
    @(negedge clk);
    cfg_we    <= 1'b0;

    if (cut > 0 && cut < file_bytes.size()) begin
      for (int i = 0; i < cut; i++) send_beat(file_bytes[i], i == 0);
      n_items += cut;
    end
    foreach (file_bytes[i]) send_beat(file_bytes[i], i == 0);
    n_items += file_bytes.size();
    repeat ($urandom_range(0, 3)) send_beat(8'($urandom), 1'b0);
  endtask

  initial begin
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] off;
    logic [31:0] flen;
    logic [31:0] cmp;
    logic [15:0] sig;
    logic [15:0] dep;
    int          rows;
    int          cols;
    int          cut;

    rst_n     = 1'b0;
    s_valid   = 1'b0;
    s_data    = '0;
    s_user    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // bytes before any start of file are dropped
    repeat (3) send_beat(8'($urandom), 1'b0);

    stream_file(SIG_BM, 34, 1, 1, DEPTH_24, 0, 32'd0, 0, 0, 0);
    stream_file(SIG_BM, 34, 1, 1, DEPTH_24, 0, 32'd13, 0, 0, 0);
    stream_file(16'h5842, 34, 1, 1, DEPTH_24, 0, 32'd14, 0, 0, 0);
    stream_file(SIG_BM, 14, 1, 1, DEPTH_24, 0, 32'd14, 0, 0, 0);
    stream_file(SIG_BM, 33, 1, 1, DEPTH_24, 0, 32'd100, 0, 0, 0);
    stream_file(SIG_BM, 34, 1, 1, DEPTH_24, 1, 32'd100, 0, 0, 0);
    stream_file(SIG_BM, 34, 1, 1, 16'd32, 0, 32'd100, 0, 0, 0);
    stream_file(SIG_BM, 34, 0, 1, DEPTH_24, 0, 32'd100, 0, 0, 0);
    stream_file(SIG_BM, 34, 32'h8000_0001, 1, DEPTH_24, 0, 32'd100, 0, 0, 0);
    stream_file(SIG_BM, 34, 1, 0, DEPTH_24, 0, 32'd100, 0, 0, 0);
    stream_file(SIG_BM, 34, 4097, 1, DEPTH_24, 0, 32'hFFFF_FFFF, 0, 0, 0);
    stream_file(SIG_BM, 34, 1, 32'hFFFF_EFFF, DEPTH_24, 0, 32'hFFFF_FFFF, 0, 0, 0);
    stream_file(SIG_BM, 34, 1, 32'h8000_0000, DEPTH_24, 0, 32'hFFFF_FFFF, 0, 0, 0);
    stream_file(SIG_BM, 34, 1, 1, DEPTH_24, 0, good_len(34, 1, 1) - 1, 1, 1, 0);
    stream_file(SIG_BM, 34, 1, 1, DEPTH_24, 0, good_len(34, 1, 1), 1, 1, 0);
    stream_file(SIG_BM, 40, 3, 32'hFFFF_FFFE, DEPTH_24, 0, 32'hFFFF_FFFF, 2, 3, 0);
    stream_file(SIG_BM, 36, 2, 3, DEPTH_24, 0, good_len(36, 2, 3), 3, 2, 45);
    // largest accepted sizes: header only, the next file restarts the parser
    stream_file(SIG_BM, 34, 4096, 1, DEPTH_24, 0, good_len(34, 4096, 1), 0, 4096, 0);
    stream_file(SIG_BM, 34, 1, 4096, DEPTH_24, 0, good_len(34, 1, 4096), 0, 1, 0);
    hold_req = 1'b1;
    stream_file(SIG_BM, 34, 8, 6, DEPTH_24, 0, good_len(34, 8, 6), 6, 8, 0);

    while (n_items < 1750) begin
      if (n_items >= 1170) begin
        snd_idle = 0;
        rcv_idle = 0;
      end else if (n_items >= 580) begin
        snd_idle = 81;
        rcv_idle = 18;
      end
      cols = $urandom_range(1, 6);
      rows = $urandom_range(1, 5);
      w    = cols;
      h    = $urandom_range(1) ? 32'd0 - rows : rows;
      off  = 34 + $urandom_range(0, 7);
      flen = good_len(off, cols, rows) + $urandom_range(0, 3);
      sig  = SIG_BM;
      dep  = DEPTH_24;
      cmp  = 0;
      cut  = ($urandom_range(99) < 12) ? $urandom_range(1, 80) : 0;
      if ($urandom_range(99) < 5) flen = 32'hFFFF_FFFF;
      if ($urandom_range(99) < 30) begin
        case ($urandom_range(0, 10))
          0: flen = $urandom_range(0, 13);
          1: begin
            sig = 16'($urandom);
            if (sig == SIG_BM) sig = sig ^ 16'h0001;
          end
          2: begin
            flen = $urandom_range(14, 200);
            off  = flen + $urandom_range(0, 50);
          end
          3: off = $urandom_range(0, 33);
          4: begin
            cmp = $urandom;
            if (cmp == 0) cmp = 1;
          end
          5: begin
            dep = 16'($urandom);
            if (dep == DEPTH_24) dep = ~dep;
          end
          6: w = $urandom_range(1) ? 32'd0 : ($urandom | 32'h8000_0000);
          7: h = 32'd0;
          8: w = $urandom_range(32'h7FFF_FFFF, 4097);
          9: h = $urandom_range(1) ? $urandom_range(32'h7FFF_FFFF, 4097)
                                   : $urandom_range(32'hFFFF_EFFF, 32'h8000_0000);
          default: flen = good_len(off, cols, rows) - $urandom_range(1, 3);
        endcase
        rows = 0;
      end
      stream_file(sig, off, w, h, dep, cmp, flen, rows, cols, cut);
    end

    s_valid <= 1'b0;
    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (n_errors == 0 && n_pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
